// ===== design/vsp_pkg.sv =====
// Shared types, constants and character helpers for the version string parser.
package vsp_pkg;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_MAJOR  = 4'd1,
    PH_MINOR0 = 4'd2,
    PH_MINOR  = 4'd3,
    PH_WS1    = 4'd4,
    PH_SP_P   = 4'd5,
    PH_SP0    = 4'd6,
    PH_SP     = 4'd7,
    PH_WS2    = 4'd8,
    PH_BMATCH = 4'd9,
    PH_BUILD0 = 4'd10,
    PH_BUILD  = 4'd11,
    PH_DONE   = 4'd12,
    PH_FAIL   = 4'd13
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  match_pos;
    logic [5:0]  major;
    logic [5:0]  minor;
    logic [4:0]  pack;
    logic [12:0] build;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase:     PH_LEAD,
    match_pos: 3'd0,
    major:     6'd0,
    minor:     6'd0,
    pack:      5'd0,
    build:     13'd0
  };

  localparam logic [12:0] LimMajor = 13'd32;
  localparam logic [12:0] LimMinor = 13'd32;
  localparam logic [12:0] LimPack  = 13'd16;
  localparam logic [12:0] LimBuild = 13'd4096;

  localparam logic [2:0] BuildLen = 3'd6;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharUpS   = 8'h53;
  localparam logic [7:0] CharUpP   = 8'h50;
  localparam logic [7:0] CharLowB  = 8'h62;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam int unsigned WordWidth = 28;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CharSpace) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= CharUpA) && (c <= CharUpZ)) ? c + 8'd32 : c;
  endfunction

  // Characters of the lower-case keyword "build " by position.
  function automatic logic [7:0] build_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h75;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6C;
      3'd4:    ch = 8'h64;
      3'd5:    ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Multiply by ten and add a digit, pinned at the limit.
  function automatic logic [12:0] accum(input logic [12:0] v, input logic [7:0] c,
                                        input logic [12:0] lim);
    logic [16:0] n;
    logic [7:0]  d;
    d = c - CharZero;
    n = ({4'd0, v} * 17'd10) + {9'd0, d};
    if ((v >= lim) || (n >= {4'd0, lim})) begin
      return lim;
    end
    return n[12:0];
  endfunction

endpackage

// ===== design/vsp_step.sv =====
// One character step of the parse state machine.
module vsp_step (
  input  vsp_pkg::parse_state_t cur,
  input  logic [7:0]            ch,
  output vsp_pkg::parse_state_t nxt
);

  vsp_pkg::parse_state_t after_sp;
  vsp_pkg::parse_state_t after_minor;
  logic                  digit;
  logic [7:0]            digit_val;

  assign digit     = vsp_pkg::is_digit(ch);
  assign digit_val = ch - vsp_pkg::CharZero;

  // Follow-on after the pack part, or where it was absent.
  always_comb begin
    after_sp = cur;
    if (vsp_pkg::is_ws(ch)) begin
      after_sp.phase = vsp_pkg::PH_WS2;
    end else if (vsp_pkg::to_lower(ch) == vsp_pkg::CharLowB) begin
      after_sp.match_pos = 3'd1;
      after_sp.phase     = vsp_pkg::PH_BMATCH;
    end else begin
      after_sp.phase = vsp_pkg::PH_DONE;
    end
  end

  always_comb begin
    after_minor = after_sp;
    if (vsp_pkg::is_ws(ch)) begin
      after_minor = cur;
      after_minor.phase = vsp_pkg::PH_WS1;
    end else if (ch == vsp_pkg::CharUpS) begin
      after_minor = cur;
      after_minor.phase = vsp_pkg::PH_SP_P;
    end
  end

  always_comb begin
    nxt = cur;
    case (cur.phase)
      vsp_pkg::PH_LEAD: begin
        if (digit) begin
          nxt.major = digit_val[5:0];
          nxt.phase = vsp_pkg::PH_MAJOR;
        end else if (!vsp_pkg::is_ws(ch)) begin
          nxt.phase = vsp_pkg::PH_FAIL;
        end
      end
      vsp_pkg::PH_MAJOR: begin
        if (digit) begin
          nxt.major = 6'(vsp_pkg::accum({7'd0, cur.major}, ch, vsp_pkg::LimMajor));
        end else begin
          nxt.phase = (ch == vsp_pkg::CharDot) ? vsp_pkg::PH_MINOR0 : vsp_pkg::PH_FAIL;
        end
      end
      vsp_pkg::PH_MINOR0: begin
        if (digit) begin
          nxt.minor = digit_val[5:0];
          nxt.phase = vsp_pkg::PH_MINOR;
        end else begin
          nxt.phase = vsp_pkg::PH_FAIL;
        end
      end
      vsp_pkg::PH_MINOR: begin
        if (digit) begin
          nxt.minor = 6'(vsp_pkg::accum({7'd0, cur.minor}, ch, vsp_pkg::LimMinor));
        end else begin
          nxt = after_minor;
        end
      end
      vsp_pkg::PH_WS1: begin
        nxt = after_minor;
      end
      vsp_pkg::PH_SP_P: begin
        nxt.phase = (ch == vsp_pkg::CharUpP) ? vsp_pkg::PH_SP0 : vsp_pkg::PH_DONE;
      end
      vsp_pkg::PH_SP0: begin
        if (digit) begin
          nxt.pack  = digit_val[4:0];
          nxt.phase = vsp_pkg::PH_SP;
        end else begin
          nxt.phase = vsp_pkg::PH_FAIL;
        end
      end
      vsp_pkg::PH_SP: begin
        if (digit) begin
          nxt.pack = 5'(vsp_pkg::accum({8'd0, cur.pack}, ch, vsp_pkg::LimPack));
        end else begin
          nxt = after_sp;
        end
      end
      vsp_pkg::PH_WS2: begin
        nxt = after_sp;
      end
      vsp_pkg::PH_BMATCH: begin
        if ((cur.match_pos < vsp_pkg::BuildLen) &&
            (vsp_pkg::to_lower(ch) == vsp_pkg::build_char(cur.match_pos))) begin
          nxt.match_pos = cur.match_pos + 3'd1;
          if (cur.match_pos + 3'd1 == vsp_pkg::BuildLen) begin
            nxt.phase = vsp_pkg::PH_BUILD0;
          end
        end else begin
          nxt.phase = vsp_pkg::PH_DONE;
        end
      end
      vsp_pkg::PH_BUILD0: begin
        if (digit) begin
          nxt.build = {9'd0, digit_val[3:0]};
          nxt.phase = vsp_pkg::PH_BUILD;
        end else begin
          nxt.phase = vsp_pkg::PH_FAIL;
        end
      end
      vsp_pkg::PH_BUILD: begin
        if (digit) begin
          nxt.build = vsp_pkg::accum(cur.build, ch, vsp_pkg::LimBuild);
        end else begin
          nxt.phase = vsp_pkg::PH_DONE;
        end
      end
      vsp_pkg::PH_DONE: begin
        nxt = cur;
      end
      default: begin
        nxt.phase = vsp_pkg::PH_FAIL;
      end
    endcase
  end

endmodule

// ===== design/version_string_parser_core.sv =====
// Top level of the version string parser: input register, parse step and result register.
//
// Feed a version string one character per item on the slave side, with tlast on the
// final character; one packed version word comes out for each string. The block takes
// one item every clock cycle. Each item lands in an input register; from there one step of
// the parse state machine consumes it, and on a final character a second copy of that
// step consumes the implied terminating zero byte, so the result register loads the
// version word straight from the final item in the input register. The combinational
// parse step (one phase transition plus a multiply-by-ten-and-add per field accumulator)
// is what sets this rate. The input side only waits while a final-character item sits in
// the input register and the previous word has not yet been taken. Malformed strings,
// and any field at or above its limit (major 32, minor 32, pack 16, build 4096), give a
// word of zero; text after the parse ends, including anything behind a zero byte, is
// ignored. All parse state returns to its reset value after each word.
module version_string_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [27:0] version_word, [31:28] zero
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Parse state
  vsp_pkg::parse_state_t state;
  vsp_pkg::parse_state_t state_char;
  vsp_pkg::parse_state_t state_term;

  logic [vsp_pkg::WordWidth-1:0] word_next;
  logic [vsp_pkg::WordWidth-1:0] word;
  logic                          advance;

  // Step on the received character
  vsp_step u_step_char (
    .cur (state),
    .ch  (in_byte),
    .nxt (state_char)
  );

  // Step on the implied terminating zero after the final character
  vsp_step u_step_term (
    .cur (state_char),
    .ch  (vsp_pkg::CharNul),
    .nxt (state_term)
  );

  // Pack the fields; zero unless parsing finished cleanly and every field is in range
  always_comb begin
    word_next = '0;
    if ((state_term.phase == vsp_pkg::PH_DONE) &&
        ({7'd0, state_term.major} < vsp_pkg::LimMajor) &&
        ({7'd0, state_term.minor} < vsp_pkg::LimMinor) &&
        ({8'd0, state_term.pack}  < vsp_pkg::LimPack)  &&
        (state_term.build < vsp_pkg::LimBuild)) begin
      word_next = {1'b0, state_term.major[4:0], 1'b0, state_term.minor[4:0],
                   state_term.pack[3:0], state_term.build[11:0]};
    end
  end

  // Advance the held item unless it is final and the result register is still occupied
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload of the input register: load on every accepted item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Parse state: drop back to reset after each final character
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsp_pkg::StateReset;
    end else if (advance) begin
      state <= in_last ? vsp_pkg::StateReset : state_char;
    end
  end

  // Result register valid: set on a final character, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      word <= word_next;
    end
  end

  assign m_tdata = {{(32 - vsp_pkg::WordWidth){1'b0}}, word};

endmodule
